// File: rtl/mtt_pkg.sv
`timescale 1ns / 1ps

package mtt_pkg;

  // defaults for the top level parameters
  localparam int PITCH_COUNT_DEF = 128;
  localparam int TIME_BITS_DEF   = 32;

  // fixed field widths
  localparam int PITCH_W  = 7;
  localparam int LEVEL_W  = 7;
  localparam int DELTA_W  = 20;
  localparam int TICKS_W  = 32;

  // event kinds
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_DAMPER   = 2'd2;

  // damper levels
  localparam logic [LEVEL_W-1:0] LVL_DAMPER_UP   = 7'd0;
  localparam logic [LEVEL_W-1:0] LVL_DAMPER_DOWN = 7'd1;

  // record kinds
  localparam logic REC_NOTE   = 1'b0;
  localparam logic REC_DAMPER = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [DELTA_W-1:0] delta_ticks;
    logic [PITCH_W-1:0] pitch;
    logic [LEVEL_W-1:0] level;
  } in_word_t;

  typedef struct packed {
    logic               record_kind;
    logic [PITCH_W-1:0] note_pitch;
    logic [LEVEL_W-1:0] note_volume;
    logic [TICKS_W-1:0] start_ticks;
    logic [TICKS_W-1:0] stop_ticks;
  } out_word_t;

endpackage

// File: rtl/mtt_note_mem.sv
`timescale 1ns / 1ps

module mtt_note_mem #(
  parameter int Depth = 128,
  parameter int AddrW = 7,
  parameter int DataW = 39
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // single port, read data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/midi_event_to_note_tracker_top.sv
`timescale 1ns / 1ps
// a record is registered in the second stage when its event word is taken, then in the
// output register, from which it can leave
// throughput: one event word per cycle while the output is not stalled, as each event
// makes at most one read or one write on the single port of the note table
// reset: asynchronous active low; clears time, damper state, active marks and valids,
// the note table itself is not cleared (an entry is read only after being written)

module midi_event_to_note_tracker_top
  import mtt_pkg::*;
#(
  parameter int PITCH_COUNT = PITCH_COUNT_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  // table index width, at least one bit
  localparam int IdxW  = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;
  // table word: start time above volume
  localparam int DataW = TIME_BITS + LEVEL_W;

  // ---------------------------------------------------------------
  // front stage: time update, active marks, damper, table access
  // ---------------------------------------------------------------
  logic                   in_acc;
  logic                   s1_adv;
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [TIME_BITS-1:0]   now;
  logic [PITCH_COUNT-1:0] active_q, active_d;
  logic [TIME_BITS-1:0]   dstart_q, dstart_d;
  logic                   dact_q, dact_d;
  logic                   in_range;
  logic [IdxW-1:0]        idx;
  logic                   mem_we, mem_re;
  logic [DataW-1:0]       mem_rdata;
  logic                   emit;
  logic                   emit_kind;

  assign now      = time_q + TIME_BITS'(in_word_i.delta_ticks);
  assign in_range = ({1'b0, in_word_i.pitch} < (PITCH_W + 1)'(PITCH_COUNT));
  assign idx      = IdxW'(in_word_i.pitch);
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    time_d    = time_q;
    active_d  = active_q;
    dstart_d  = dstart_q;
    dact_d    = dact_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    emit      = 1'b0;
    emit_kind = REC_NOTE;
    if (in_acc) begin
      case (in_word_i.kind)
        KIND_NOTE_ON: begin
          time_d = now;
          if (in_range) begin
            mem_we        = 1'b1;
            active_d[idx] = 1'b1;
          end
        end
        KIND_NOTE_OFF: begin
          time_d = now;
          // only an active pitch yields a note record
          if (in_range && active_q[idx]) begin
            mem_re        = 1'b1;
            active_d[idx] = 1'b0;
            emit          = 1'b1;
          end
        end
        KIND_DAMPER: begin
          if (in_word_i.level == LVL_DAMPER_DOWN) begin
            time_d   = now;
            dstart_d = now;
            dact_d   = 1'b1;
          end else if (in_word_i.level == LVL_DAMPER_UP) begin
            time_d = now;
            if (dact_q) begin
              dact_d    = 1'b0;
              emit      = 1'b1;
              emit_kind = REC_DAMPER;
            end
          end
          // other damper levels leave time alone
        end
        default: begin
          // unused kind code: ignored, time holds
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      active_q <= '0;
      dstart_q <= '0;
      dact_q   <= 1'b0;
    end else begin
      time_q   <= time_d;
      active_q <= active_d;
      dstart_q <= dstart_d;
      dact_q   <= dact_d;
    end
  end

  // note table: write on note on, read on a live note off. a write lands
  // at the edge of its own event, so the next event already sees it and
  // no forwarding path is needed
  mtt_note_mem #(
    .Depth (PITCH_COUNT),
    .AddrW (IdxW),
    .DataW (DataW)
  ) u_note_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (idx),
    .wdata_i ({now, in_word_i.level}),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------
  // second stage: waits for the table read data
  // ---------------------------------------------------------------
  logic                 s1_valid_q;
  logic                 s1_emit_q;
  logic                 s1_kind_q;
  logic [PITCH_W-1:0]   s1_pitch_q;
  logic [TIME_BITS-1:0] s1_dstart_q;
  logic [TIME_BITS-1:0] s1_stop_q;

  // the read data register holds while this stage stalls
  assign s1_adv     = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc;
      s1_emit_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= emit_kind;
      s1_pitch_q  <= in_word_i.pitch;
      s1_dstart_q <= dstart_q;
      s1_stop_q   <= now;
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  logic      out_valid_q;
  out_word_t out_q, out_d;
  logic      out_load;

  assign out_load = s1_valid_q && s1_emit_q && s1_adv;

  always_comb begin
    out_d.record_kind = s1_kind_q;
    out_d.stop_ticks  = TICKS_W'(s1_stop_q);
    if (s1_kind_q == REC_NOTE) begin
      out_d.note_pitch  = s1_pitch_q;
      out_d.note_volume = mem_rdata[LEVEL_W-1:0];
      out_d.start_ticks = TICKS_W'(mem_rdata[DataW-1:LEVEL_W]);
    end else begin
      out_d.note_pitch  = '0;
      out_d.note_volume = '0;
      out_d.start_ticks = TICKS_W'(s1_dstart_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------

  // a stalled second stage keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_stop_q) && $stable(s1_emit_q)))
    else $error("second stage lost its word under stall");

  // a note on in range leaves its pitch active
  a_on_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.kind == KIND_NOTE_ON && in_range) |=> active_q[$past(idx)])
    else $error("note on did not set the active mark");

  // damper down leaves the damper active with the new time as start
  a_damper_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.kind == KIND_DAMPER && in_word_i.level == LVL_DAMPER_DOWN)
    |=> (dact_q && dstart_q == time_q))
    else $error("damper down not recorded");

  // an unused kind code leaves time alone
  a_rsvd_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.kind != KIND_NOTE_ON && in_word_i.kind != KIND_NOTE_OFF
     && in_word_i.kind != KIND_DAMPER) |=> $stable(time_q))
    else $error("ignored word moved the time");

  // a record leaves only for a word that asked for one
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (s1_valid_q && s1_emit_q))
    else $error("record loaded without a source word");

endmodule

// File: verif/note_record_checker.sv
`timescale 1ns / 1ps

module note_record_checker
  import mtt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        records_pending_o
);

  localparam int PITCHES = PITCH_COUNT_DEF;

  logic [TICKS_W-1:0] clock_ticks;
  logic [TICKS_W-1:0] pitch_start [PITCHES];
  logic [LEVEL_W-1:0] pitch_volume [PITCHES];
  logic               pitch_held [PITCHES];
  logic [TICKS_W-1:0] pedal_start;
  logic               pedal_down;
  out_word_t          expected_records [$];
  int                 mismatches = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [TICKS_W-1:0] got,
                             input logic [TICKS_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // advance the tick count and queue the record an event word closes, if any
  task automatic track_event(input in_word_t w);
    logic [TICKS_W-1:0] now;
    out_word_t          rec;
    now = clock_ticks + TICKS_W'(w.delta_ticks);
    rec = '0;
    case (w.kind)
      KIND_NOTE_ON: begin
        clock_ticks = now;
        if (int'(w.pitch) < PITCHES) begin
          pitch_start[w.pitch]  = now;
          pitch_volume[w.pitch] = w.level;
          pitch_held[w.pitch]   = 1'b1;
        end
      end
      KIND_NOTE_OFF: begin
        clock_ticks = now;
        if (int'(w.pitch) < PITCHES && pitch_held[w.pitch]) begin
          pitch_held[w.pitch] = 1'b0;
          rec.record_kind = REC_NOTE;
          rec.note_pitch  = w.pitch;
          rec.note_volume = pitch_volume[w.pitch];
          rec.start_ticks = pitch_start[w.pitch];
          rec.stop_ticks  = now;
          expected_records = {expected_records, rec};
        end
      end
      KIND_DAMPER: begin
        if (w.level == LVL_DAMPER_DOWN) begin
          clock_ticks = now;
          pedal_start = now;
          pedal_down  = 1'b1;
        end else if (w.level == LVL_DAMPER_UP) begin
          clock_ticks = now;
          if (pedal_down) begin
            pedal_down = 1'b0;
            rec.record_kind = REC_DAMPER;
            rec.start_ticks = pedal_start;
            rec.stop_ticks  = now;
            expected_records = {expected_records, rec};
          end
        end
        // any other damper level is dropped and time stands still
      end
      default: ;  // unused kind code, dropped without advancing time
    endcase
  endtask

  task automatic compare_record(input out_word_t got);
    out_word_t want;
    if (expected_records.size() == 0) begin
      report_mismatch($sformatf("unexpected record kind %0d pitch %0d start %0d stop %0d",
                                got.record_kind, got.note_pitch, got.start_ticks,
                                got.stop_ticks));
    end else begin
      want = expected_records.pop_front();
      check_field("record_kind", TICKS_W'(got.record_kind), TICKS_W'(want.record_kind));
      check_field("note_pitch", TICKS_W'(got.note_pitch), TICKS_W'(want.note_pitch));
      check_field("note_volume", TICKS_W'(got.note_volume), TICKS_W'(want.note_volume));
      check_field("start_ticks", got.start_ticks, want.start_ticks);
      check_field("stop_ticks", got.stop_ticks, want.stop_ticks);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_ticks = '0;
      pedal_start = '0;
      pedal_down  = 1'b0;
      for (int i = 0; i < PITCHES; i++) pitch_held[i] = 1'b0;
      expected_records.delete();
      records_pending_o <= 0;
    end else begin
      // a record can never belong to the word taken on the same edge
      if (out_valid_i && out_ready_i) compare_record(out_word_i);
      if (in_valid_i && in_ready_i) track_event(in_word_i);
      records_pending_o <= expected_records.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// File: verif/midi_event_to_note_tracker_top_tb.sv
`timescale 1ns / 1ps

module midi_event_to_note_tracker_top_tb;
  import mtt_pkg::*;

  // kind code with no meaning to the block, must be swallowed
  localparam logic [1:0]         KIND_UNUSED   = 2'd3;
  localparam logic [DELTA_W-1:0] DELTA_MAX     = '1;
  localparam int                 RANDOM_EVENTS = 600;
  localparam int                 CYCLE_LIMIT   = 1000000;
  // wait after the drain so that a late stray record is still seen
  localparam int                 SETTLE_CYCLES = 8;

  typedef enum int {RX_FREE, RX_RANDOM, RX_CHOKED} rx_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  int       fail_count;
  int       records_pending;
  int       cycle_count = 0;
  int       burst_left  = 0;
  rx_mode_e rx_mode     = RX_FREE;
  int       rx_left     = 0;

  // small set of pitches so that most note offs find a sounding note
  logic [PITCH_W-1:0] pitch_pool [8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  midi_event_to_note_tracker_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  note_record_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_word_i         (in_word_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_word_i        (out_word_o),
    .fail_count_o      (fail_count),
    .records_pending_o (records_pending)
  );

  // watchdog, a hung handshake must not run forever
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure: long stretches of free flow, coin-toss stalls, or a
  // nearly blocked output, a new mode picked at random whenever a run ends
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
      default:   out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // present one word and hold it until taken; entered and left at a falling
  // edge, valid stays high between words of one burst
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_event(input logic [1:0] kind, input logic [DELTA_W-1:0] delta,
                            input logic [PITCH_W-1:0] pitch,
                            input logic [LEVEL_W-1:0] level);
    in_word_t w;
    w.kind        = kind;
    w.delta_ticks = delta;
    w.pitch       = pitch;
    w.level       = level;
    send_word(w);
  endtask

  // mostly on and off pairs over the pitch pool with damper presses mixed in;
  // a few odd damper levels and unused kinds as noise
  task automatic random_event();
    in_word_t w;
    int       roll;
    int       lvl_roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) w.pitch = pitch_pool[$urandom_range(0, 7)];
    else w.pitch = PITCH_W'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0:       w.delta_ticks = '0;
      1:       w.delta_ticks = DELTA_W'($urandom_range(1, 15));
      2:       w.delta_ticks = DELTA_W'($urandom_range(16, 4095));
      default: w.delta_ticks = DELTA_W'($urandom_range(0, DELTA_MAX));
    endcase
    w.level = LEVEL_W'($urandom_range(0, 127));
    if (roll < 40) begin
      w.kind = KIND_NOTE_ON;
    end else if (roll < 80) begin
      w.kind = KIND_NOTE_OFF;
    end else if (roll < 95) begin
      w.kind = KIND_DAMPER;
      lvl_roll = $urandom_range(0, 9);
      // mostly proper down and up, now and then a level the block drops
      if (lvl_roll < 5) w.level = LVL_DAMPER_DOWN;
      else if (lvl_roll < 9) w.level = LVL_DAMPER_UP;
    end else begin
      w.kind = KIND_UNUSED;
    end
    send_word(w);
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < 8; k++) pitch_pool[k] = PITCH_W'($urandom_range(0, 127));
  endtask

  // hold the sender off until every expected record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (records_pending != 0);
    @(negedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words go out as one unbroken burst so that the same-pitch
    // pairs really arrive back to back
    burst_left = 25;
    // field extremes: lowest and highest pitch, volume and delta
    send_event(KIND_NOTE_ON,  '0,        7'd0,   7'd0);
    send_event(KIND_NOTE_ON,  DELTA_MAX, 7'd127, 7'd127);
    send_event(KIND_NOTE_OFF, 20'd1,     7'd0,   7'd0);
    send_event(KIND_NOTE_OFF, '0,        7'd127, 7'd127);
    // note off for a pitch that is not sounding
    send_event(KIND_NOTE_OFF, 20'd3,     7'd5,   7'd9);
    // second note on for a sounding pitch overwrites start and volume
    send_event(KIND_NOTE_ON,  20'd10,    7'd60,  7'd64);
    send_event(KIND_NOTE_ON,  20'd20,    7'd60,  7'd33);
    send_event(KIND_NOTE_OFF, '0,        7'd60,  7'd0);
    // damper up with the damper never pressed
    send_event(KIND_DAMPER,   20'd7,     7'd0,   LVL_DAMPER_UP);
    // pressed twice, the later press sets the start
    send_event(KIND_DAMPER,   20'd11,    7'd0,   LVL_DAMPER_DOWN);
    send_event(KIND_DAMPER,   20'd12,    7'd99,  LVL_DAMPER_DOWN);
    // damper levels other than up and down are dropped, time stands still
    send_event(KIND_DAMPER,   20'd5,     7'd0,   7'd2);
    send_event(KIND_DAMPER,   DELTA_MAX, 7'd127, 7'd127);
    // unused kind code, likewise dropped
    send_event(KIND_UNUSED,   DELTA_MAX, 7'd127, 7'd127);
    send_event(KIND_DAMPER,   '0,        7'd0,   LVL_DAMPER_UP);
    send_event(KIND_NOTE_ON,  20'd2,     7'd42,  7'd1);
    send_event(KIND_NOTE_OFF, 20'd4,     7'd42,  7'd127);
    // interleaved notes, then on and off on one pitch as back-to-back words
    send_event(KIND_NOTE_ON,  20'd6,     7'd85,  7'd85);
    send_event(KIND_NOTE_ON,  '0,        7'd42,  7'd100);
    send_event(KIND_NOTE_OFF, 20'd1,     7'd85,  7'd3);
    send_event(KIND_NOTE_OFF, '0,        7'd42,  7'd0);
    send_event(KIND_NOTE_ON,  20'd8,     7'd1,   7'd127);
    send_event(KIND_NOTE_OFF, '0,        7'd1,   7'd0);
    drain();

    // random mix with bursty sender and varied deltas
    refresh_pool();
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % 40 == 39) refresh_pool();
      random_event();
    end
    drain();

    // catch any stray record that turns up after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mtt_pkg.sv
rtl/mtt_note_mem.sv
rtl/midi_event_to_note_tracker_top.sv
verif/note_record_checker.sv
verif/midi_event_to_note_tracker_top_tb.sv
